// ===== hdl/h264_annexb_nal_scanner_top_defines.svh =====
// Assertion macros shared by the scanner checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef H264_ANNEXB_NAL_SCANNER_TOP_DEFINES_SVH
`define H264_ANNEXB_NAL_SCANNER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define H264NS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("h264ns check failed");

// Next-cycle implication, disabled while reset is low
`define H264NS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("h264ns check failed");

`endif

// ===== hdl/h264ns_pkg.sv =====
// Shared types and constants for the H.264 Annex B NAL scanner.
// No dependencies; imported by every scanner module.
package h264ns_pkg;

    localparam int unsigned DATA_W     = 8;
    localparam int unsigned TYPE_W     = 6;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned OUT_DATA_W = 32;

    localparam logic [31:0] COUNT_MAX_DEFAULT = 32'd65535;

    // NAL unit type codes of interest
    localparam logic [4:0] NAL_SLICE = 5'd1;
    localparam logic [4:0] NAL_IDR   = 5'd5;
    localparam logic [4:0] NAL_SPS   = 5'd7;
    localparam logic [4:0] NAL_PPS   = 5'd8;

    localparam logic [TYPE_W-1:0] TYPE_NONE    = 6'h3f;
    localparam logic [1:0]        ZERO_RUN_SAT = 2'd2;
    localparam logic [7:0]        START_BYTE   = 8'h01;

    // One byte leaving the input register toward the scan core
    typedef struct packed {
        logic              commit;
        logic              last_byte;
        logic [DATA_W-1:0] data_byte;
    } step_t;

    // Summary result; packed so bit 0 is first_type[0]
    typedef struct packed {
        logic               slice_seen;
        logic               has_idr;
        logic               has_pps;
        logic               has_sps;
        logic [COUNT_W-1:0] unit_total;
        logic [TYPE_W-1:0]  last_type;
        logic [TYPE_W-1:0]  first_type;
    } summary_t;

endpackage

// ===== hdl/h264ns_in_stage.sv =====
// Input register for the byte stream with its handshake.
// Depends on h264ns_pkg.
module h264ns_in_stage
    import h264ns_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  logic              s_axis_tlast,   // last_byte
    input  logic              out_free,
    output step_t             step
);

    logic              valid_reg;
    logic              valid_next;
    logic [DATA_W-1:0] byte_reg;
    logic              last_reg;
    logic              advance;
    logic              take;

    // A last byte needs room in the output register; other bytes always move on
    assign advance       = valid_reg && (!last_reg || out_free);
    assign s_axis_tready = !valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign valid_next    = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
    end

    assign step.commit    = advance;
    assign step.last_byte = last_reg;
    assign step.data_byte = byte_reg;

endmodule

// ===== hdl/h264ns_scan_core.sv =====
// Start code tracking and per-unit classification, one byte per cycle while the input register is not stalled.
// Depends on h264ns_pkg.
module h264ns_scan_core
    import h264ns_pkg::*;
#(
    parameter logic [31:0] COUNT_MAX = COUNT_MAX_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  step_t    step,
    output summary_t summary
);

    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        (COUNT_MAX > 32'h0000_ffff) ? {COUNT_W{1'b1}} : COUNT_MAX[COUNT_W-1:0];

    // Summary value at reset and after each last byte of a stream
    localparam summary_t SUM_INIT = '{
        slice_seen: 1'b0,
        has_idr:    1'b0,
        has_pps:    1'b0,
        has_sps:    1'b0,
        unit_total: {COUNT_W{1'b0}},
        last_type:  TYPE_NONE,
        first_type: TYPE_NONE
    };

    logic [1:0]         zero_run_reg,     zero_run_next;
    logic               code_seen_reg,    code_seen_next;
    logic               head_pending_reg, head_pending_next;
    logic [DATA_W-1:0]  nal_head_reg,     nal_head_next;
    logic               nonzero_reg,      nonzero_next;
    summary_t           sum_reg,          sum_next;

    logic               is_code;
    logic               record;
    logic [4:0]         head_type;

    // Byte-level scan and unit close detection
    always_comb
    begin
        is_code = (step.data_byte == START_BYTE) && (zero_run_reg >= ZERO_RUN_SAT);
        if (is_code)
        begin
            zero_run_next     = 2'd0;
            code_seen_next    = 1'b1;
            head_pending_next = 1'b1;
            nal_head_next     = nal_head_reg;
            nonzero_next      = 1'b0;
            record            = code_seen_reg && nonzero_reg;
        end
        else
        begin
            code_seen_next    = code_seen_reg;
            head_pending_next = 1'b0;
            nal_head_next     = head_pending_reg ? step.data_byte : nal_head_reg;
            nonzero_next      = nonzero_reg || (step.data_byte != '0);
            if (step.data_byte != '0)
            begin
                zero_run_next = 2'd0;
            end
            else if (zero_run_reg < ZERO_RUN_SAT)
            begin
                zero_run_next = zero_run_reg + 2'd1;
            end
            else
            begin
                zero_run_next = zero_run_reg;
            end
            // end of stream closes the open unit, or the whole stream if no code
            if (step.last_byte)
            begin
                record = code_seen_reg ? (nonzero_next && !head_pending_next) : 1'b1;
            end
            else
            begin
                record = 1'b0;
            end
        end
    end

    // Summary update for a closed unit
    always_comb
    begin
        head_type = nal_head_next[4:0];
        sum_next  = sum_reg;
        if (record)
        begin
            if (sum_reg.first_type == TYPE_NONE)
            begin
                sum_next.first_type = {1'b0, head_type};
            end
            sum_next.last_type = {1'b0, head_type};
            if (sum_reg.unit_total < COUNT_LIMIT)
            begin
                sum_next.unit_total = sum_reg.unit_total + 1'b1;
            end
            case (head_type)
                NAL_SPS:   sum_next.has_sps = 1'b1;
                NAL_PPS:   sum_next.has_pps = 1'b1;
                NAL_IDR:
                begin
                    sum_next.has_idr    = 1'b1;
                    sum_next.slice_seen = 1'b1;
                end
                NAL_SLICE: sum_next.slice_seen = 1'b1;
                default:   ;
            endcase
        end
    end

    assign summary = sum_next;

    // State registers; a last byte returns everything to reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg     <= 2'd0;
            code_seen_reg    <= 1'b0;
            head_pending_reg <= 1'b1;
            nal_head_reg     <= '0;
            nonzero_reg      <= 1'b0;
            sum_reg          <= SUM_INIT;
        end
        else if (step.commit)
        begin
            if (step.last_byte)
            begin
                zero_run_reg     <= 2'd0;
                code_seen_reg    <= 1'b0;
                head_pending_reg <= 1'b1;
                nal_head_reg     <= '0;
                nonzero_reg      <= 1'b0;
                sum_reg          <= SUM_INIT;
            end
            else
            begin
                zero_run_reg     <= zero_run_next;
                code_seen_reg    <= code_seen_next;
                head_pending_reg <= head_pending_next;
                nal_head_reg     <= nal_head_next;
                nonzero_reg      <= nonzero_next;
                sum_reg          <= sum_next;
            end
        end
    end

endmodule

// ===== hdl/h264ns_out_stage.sv =====
// Output register holding one summary until the downstream transfer.
// Depends on h264ns_pkg.
module h264ns_out_stage
    import h264ns_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  step_t                 step,
    input  summary_t              summary,
    output logic                  out_free,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic     valid_reg;
    logic     valid_next;
    summary_t data_reg;
    logic     load;

    assign load       = step.commit && step.last_byte;
    assign out_free   = !valid_reg || m_axis_tready;
    assign valid_next = load || (valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= summary;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule

// ===== hdl/h264_annexb_nal_scanner_top.sv =====
// A summary passes through the input register and then the output register; an untaken summary can stall it.
// One byte per cycle unless a last byte is held in the input register; the scan state updates once per byte.
// A last byte waits in the input register only while a previous summary is untaken.
// Reset (rst_n low, async) clears all scan state and both valid flags.
// Top level: input register, scan core, output register. Depends on h264ns_pkg.
module h264_annexb_nal_scanner_top
    import h264ns_pkg::*;
#(
    parameter logic [31:0] COUNT_MAX = COUNT_MAX_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DATA_W-1:0]     s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tlast,   // last_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [5:0] first_type, [11:6] last_type, [27:12] unit count,
    // [28] has_sps, [29] has_pps, [30] has_idr, [31] slice seen
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    step_t    step;
    summary_t summary;
    logic     out_free;

    h264ns_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .out_free      (out_free),
        .step          (step)
    );

    h264ns_scan_core #(
        .COUNT_MAX (COUNT_MAX)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .summary (summary)
    );

    h264ns_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .summary       (summary),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== hdl/h264ns_checker.sv =====
// Port-level checks for the NAL scanner, bound to the top level.
// Depends on h264ns_pkg and h264_annexb_nal_scanner_top_defines.svh.
`include "h264_annexb_nal_scanner_top_defines.svh"

module h264ns_checker
    import h264ns_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A summary waits until it is taken
    `H264NS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // Input stalls only behind an untaken summary
    `H264NS_ASSERT_NOW(a_in_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

    // No counted unit means no types and no flags
    `H264NS_ASSERT_NOW(a_empty_summary, m_axis_tvalid && (m_axis_tdata[27:12] == '0),
        (m_axis_tdata[5:0] == TYPE_NONE) && (m_axis_tdata[11:6] == TYPE_NONE) &&
        (m_axis_tdata[31:28] == '0))

    // A counted unit always leaves a valid first and last type
    `H264NS_ASSERT_NOW(a_typed_summary, m_axis_tvalid && (m_axis_tdata[27:12] != '0),
        !m_axis_tdata[5] && !m_axis_tdata[11])

    // IDR is a slice
    `H264NS_ASSERT_NOW(a_idr_slice, m_axis_tvalid && m_axis_tdata[30], m_axis_tdata[31])

endmodule

bind h264_annexb_nal_scanner_top h264ns_checker u_h264ns_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
